// ----- hw/rtl/one_shot_timer_pool_unit_assert.svh -----
// Assertion macros for the timer pool.
`ifndef ONE_SHOT_TIMER_POOL_UNIT_ASSERT_SVH
`define ONE_SHOT_TIMER_POOL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define OSTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OSTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ostp_pkg.sv -----
package ostp_pkg;

    localparam int unsigned ReqW    = 3;
    localparam int unsigned SlotW   = 4;
    localparam int unsigned PeriodW = 16;
    localparam int unsigned TickW   = 32;
    localparam int unsigned StatusW = 3;
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 8;

    typedef enum logic [ReqW-1:0] {
        REQ_CREATE  = 3'd0,
        REQ_FREE    = 3'd1,
        REQ_OPEN    = 3'd2,
        REQ_CLOSE   = 3'd3,
        REQ_PROCESS = 3'd4,
        REQ_TICK    = 3'd5
    } t_req;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 3'd0,
        ST_NO_FREE  = 3'd1,
        ST_BAD_SLOT = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_NOTHING  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CREATE,
        S_PROC,
        S_FLUSH
    } t_state;

endpackage

// ----- hw/rtl/one_shot_timer_pool_unit.sv -----
// Free/open/close/tick and unused codes go from accept to the EXEC state, then into the result register.
// Create scans the slots one per cycle until it finds a free slot or reaches the last one.
// Process checks one slot per cycle on a shared subtract/compare, except while a held hit
// waits on a stalled output. One request in flight at a time.
// Reset (synchronous, active low) clears in-use and armed flags, the tick counter
// and the sequencer; start ticks and periods are not cleared.
module one_shot_timer_pool_unit #(
    parameter int unsigned SLOTS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input transaction
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [3:0] slot, [19:4] period, [23:20] zero
    input  logic [ostp_pkg::InDataW-1:0] i_s_tdata,
    // [2:0] req_type
    input  logic [ostp_pkg::ReqW-1:0]   i_s_tuser,
    // result transaction
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [3:0] slot_out, [7:4] zero
    output logic [ostp_pkg::OutDataW-1:0] o_m_tdata,
    // [2:0] status
    output logic [ostp_pkg::StatusW-1:0] o_m_tuser,
    output logic                        o_m_tlast
);
    import ostp_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [SlotW-1:0]     r_slot;
    logic [PeriodW-1:0]   r_period;
    logic [IW-1:0]        r_idx;

    logic [SLOTS-1:0]     r_in_use;
    logic [SLOTS-1:0]     r_armed;
    logic [TickW-1:0]     r_start [SLOTS];
    logic [PeriodW-1:0]   r_per [SLOTS];
    logic [TickW-1:0]     r_now;

    logic                 r_pend_v;
    logic [IW-1:0]        r_pend_idx;

    logic                 r_out_v;
    t_status              r_out_status;
    logic [SlotW-1:0]     r_out_slot;
    logic                 r_out_last;

    logic                 s_acc;
    logic                 out_free;
    logic                 slot_bad;
    logic [IW-1:0]        slot_idx;
    logic [TickW-1:0]     elapsed;
    logic                 due;

    // sequencer outputs
    logic                 out_load;
    t_status              out_status;
    logic [SlotW-1:0]     out_slot;
    logic                 out_last;
    logic                 idx_inc;
    logic                 create_wr;
    logic                 free_wr;
    logic                 open_wr;
    logic                 close_wr;
    logic                 disarm_wr;
    logic                 tick_inc;
    logic                 pend_set;
    logic                 pend_clr;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_v || i_m_tready;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {(OutDataW - SlotW)'(0), r_out_slot};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    assign slot_bad = ({1'b0, r_slot} >= (SlotW + 1)'(SLOTS));
    assign slot_idx = r_slot[IW-1:0];

    // shared unit: elapsed ticks against the period of the slot under the scan index
    assign elapsed = r_now - r_start[r_idx];
    assign due     = r_in_use[r_idx] && r_armed[r_idx]
                     && (elapsed >= {(TickW - PeriodW)'(0), r_per[r_idx]});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (t_req'(i_s_tuser))
                        REQ_CREATE:  n_state = S_CREATE;
                        REQ_PROCESS: n_state = S_PROC;
                        default:     n_state = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                if (out_free) n_state = S_IDLE;
            end
            S_CREATE: begin
                if (out_free && (!r_in_use[r_idx] || r_idx == LastIdx)) n_state = S_IDLE;
            end
            S_PROC: begin
                if (r_idx == LastIdx && !(due && r_pend_v && !out_free)) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_load   = 1'b0;
        out_status = ST_OK;
        out_slot   = '0;
        out_last   = 1'b1;
        idx_inc    = 1'b0;
        create_wr  = 1'b0;
        free_wr    = 1'b0;
        open_wr    = 1'b0;
        close_wr   = 1'b0;
        disarm_wr  = 1'b0;
        tick_inc   = 1'b0;
        pend_set   = 1'b0;
        pend_clr   = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (r_req) inside
                        REQ_FREE, REQ_OPEN, REQ_CLOSE: begin
                            if (slot_bad) begin
                                out_status = ST_BAD_SLOT;
                            end else begin
                                free_wr  = (r_req == REQ_FREE);
                                open_wr  = (r_req == REQ_OPEN);
                                close_wr = (r_req == REQ_CLOSE);
                            end
                        end
                        REQ_TICK: tick_inc = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CREATE: begin
                if (!r_in_use[r_idx]) begin
                    if (out_free) begin
                        out_load  = 1'b1;
                        out_slot  = SlotW'(r_idx);
                        create_wr = 1'b1;
                    end
                end else if (r_idx == LastIdx) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_NO_FREE;
                    end
                end else begin
                    idx_inc = 1'b1;
                end
            end
            S_PROC: begin
                if (due) begin
                    // hold the newest hit back until the scan shows whether it is the last
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            out_load   = 1'b1;
                            out_status = ST_EXPIRED;
                            out_slot   = SlotW'(r_pend_idx);
                            out_last   = 1'b0;
                        end
                        pend_set  = 1'b1;
                        disarm_wr = 1'b1;
                        idx_inc   = (r_idx != LastIdx);
                    end
                end else begin
                    idx_inc = (r_idx != LastIdx);
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    pend_clr = 1'b1;
                    if (r_pend_v) begin
                        out_status = ST_EXPIRED;
                        out_slot   = SlotW'(r_pend_idx);
                    end else begin
                        out_status = ST_NOTHING;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_armed  <= '0;
            r_now    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (pend_set) begin
                r_pend_v <= 1'b1;
            end else if (pend_clr) begin
                r_pend_v <= 1'b0;
            end
            if (tick_inc) r_now <= r_now + TickW'(1);
            if (create_wr) begin
                r_in_use[r_idx] <= 1'b1;
                r_armed[r_idx]  <= 1'b1;
            end
            if (free_wr)   r_in_use[slot_idx] <= 1'b0;
            if (open_wr)   r_armed[slot_idx]  <= 1'b1;
            if (close_wr)  r_armed[slot_idx]  <= 1'b0;
            if (disarm_wr) r_armed[r_idx]     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req    <= t_req'(i_s_tuser);
            r_slot   <= i_s_tdata[SlotW-1:0];
            r_period <= i_s_tdata[SlotW +: PeriodW];
            r_idx    <= '0;
        end else if (idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (pend_set) r_pend_idx <= r_idx;
        if (create_wr) begin
            r_start[r_idx] <= r_now;
            r_per[r_idx]   <= r_period;
        end
        if (open_wr) r_start[slot_idx] <= r_now;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_slot   <= out_slot;
            r_out_last   <= out_last;
        end
    end

`include "one_shot_timer_pool_unit_assert.svh"

    `OSTP_ASSERT_NXT(a_proc_dispatch, i_clk, i_rst_n, s_acc && (i_s_tuser == REQ_PROCESS), r_state == S_PROC, "process request did not start a scan")
    `OSTP_ASSERT_IMP(a_pend_scope, i_clk, i_rst_n, r_pend_v, (r_state == S_PROC) || (r_state == S_FLUSH), "pending expiry outside a scan")
    `OSTP_ASSERT_IMP(a_nonlast_in_proc, i_clk, i_rst_n, out_load && !out_last, (r_state == S_PROC) && (out_status == ST_EXPIRED), "non-final result outside a process scan")
    `OSTP_ASSERT_NXT(a_tick_step, i_clk, i_rst_n, tick_inc, r_now == ($past(r_now) + 32'd1), "tick counter did not advance by one")
    `OSTP_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load, out_free, "result loaded over a waiting result")

endmodule
